// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BBR_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("assertion failed");
`define BBR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BBR_ASSERT(lbl, clk, rstn, prop)
`define BBR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/bbr_pkg.sv =====
// Types and constants of the byte buffer with range removal.
`default_nettype none
package bbr_pkg;

	localparam int ACT_W  = 3;
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 11;
	localparam int POS_W  = 10;

	localparam int MIN_CAP = 20;
	localparam logic [LEN_W-1:0] CAP_RESET = 11'd1024;

	typedef enum logic [ACT_W-1:0] {
		ACT_APPEND = 3'd0,
		ACT_READ   = 3'd1,
		ACT_REMOVE = 3'd2,
		ACT_CLEAR  = 3'd3,
		ACT_QUERY  = 3'd4
	} action_t;

	typedef struct packed {
		logic              wr;
		logic              sh;
		logic [BYTE_W-1:0] data;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/bbr_if.sv =====
// Channel interfaces: input items, result items and the capacity write port.
`default_nettype none
interface bbr_in_if;
	logic                       valid;
	logic                       ready;
	logic [bbr_pkg::ACT_W-1:0]  action;
	logic [bbr_pkg::BYTE_W-1:0] data_byte;
	logic                       first_of_chunk;
	logic [bbr_pkg::LEN_W-1:0]  chunk_length;
	logic [bbr_pkg::POS_W-1:0]  position;
	logic [bbr_pkg::LEN_W-1:0]  end_position;

	modport source (output valid, action, data_byte, first_of_chunk, chunk_length,
		position, end_position, input ready);
	modport sink (input valid, action, data_byte, first_of_chunk, chunk_length,
		position, end_position, output ready);
endinterface

interface bbr_out_if;
	logic                       valid;
	logic                       ready;
	logic                       status;
	logic [bbr_pkg::BYTE_W-1:0] read_byte;
	logic [bbr_pkg::LEN_W-1:0]  fill_level;
	logic [bbr_pkg::LEN_W-1:0]  free_space;
	logic                       is_empty;
	logic                       is_full;

	modport source (output valid, status, read_byte, fill_level, free_space, is_empty,
		is_full, input ready);
	modport sink (input valid, status, read_byte, fill_level, free_space, is_empty,
		is_full, output ready);
endinterface

interface bbr_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [bbr_pkg::LEN_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/bbr_cell.sv =====
// One byte cell of the buffer row: load on append, take the neighbor's byte on shift.
`default_nettype none
module bbr_cell #(
	parameter int AW  = 10,
	parameter int IDX = 0
) (
	input  wire logic                       clk,
	input  wire bbr_pkg::cell_ctl_t         ctl,
	input  wire logic [AW-1:0]              wr_idx,
	input  wire logic [AW-1:0]              sh_start,
	input  wire logic [bbr_pkg::BYTE_W-1:0] nxt,
	output      logic [bbr_pkg::BYTE_W-1:0] q
);

	localparam logic [AW-1:0] MY_IDX = AW'(IDX);

	logic [bbr_pkg::BYTE_W-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (ctl.wr && wr_idx == MY_IDX) begin
			byte_q <= ctl.data;
		end else if (ctl.sh && MY_IDX >= sh_start) begin
			byte_q <= nxt;
		end
	end

	assign q = byte_q;

endmodule
`default_nettype wire

// ===== rtl/byte_buffer_with_range_removal.sv =====
// Top level: linear byte buffer with range removal built as a row of byte cells.
//
//  channel  | dir | beat
//  ---------+-----+-----------------------------------------------------------
//  in_ch    | in  | action, data_byte, first_of_chunk, chunk_length, position,
//           |     | end_position
//  out_ch   | out | status, read_byte, fill_level, free_space, is_empty, is_full
//  cfg      | in  | capacity value
//
//  Append, read, clear and query act at once on their beat; the result is
//  registered and shows in the cycle after the input beat.
//  In a range removal in_ch waits while the cells shift the tail down by
//  one place per cycle; the result shows after the last shift.
//  Reset clears fill, chunk state and capacity (1024); cell contents are kept.
//  A stalled result holds the output register and in_ch waits behind it.
`default_nettype none
`include "assert_macros.svh"
module byte_buffer_with_range_removal #(
	parameter int BUFFER_DEPTH = 1024
) (
	input wire logic  clk,
	input wire logic  arst_n,
	bbr_in_if.sink    in_ch,
	bbr_out_if.source out_ch,
	bbr_cfg_if.sink   cfg
);

	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int EW = (CW > bbr_pkg::LEN_W) ? CW : bbr_pkg::LEN_W;

	function automatic logic [EW-1:0] sat_cap(input logic [bbr_pkg::LEN_W-1:0] c);
		logic [EW-1:0] w;
		w = EW'(c);
		if (w < EW'(bbr_pkg::MIN_CAP)) w = EW'(bbr_pkg::MIN_CAP);
		if (w > EW'(BUFFER_DEPTH)) w = EW'(BUFFER_DEPTH);
		return w;
	endfunction

	logic [bbr_pkg::LEN_W-1:0] cap_q;
	logic [CW-1:0]             fill_q;
	logic                      chunk_q;
	logic                      busy_q;
	logic [CW-1:0]             cnt_q;
	logic [AW-1:0]             start_q;
	logic                      out_valid_q;

	logic                       out_status_q;
	logic [bbr_pkg::BYTE_W-1:0] out_rbyte_q;
	logic [EW-1:0]              out_fill_q;
	logic [EW-1:0]              out_free_q;
	logic                       out_empty_q;
	logic                       out_full_q;

	logic [bbr_pkg::BYTE_W-1:0] cell_byte [BUFFER_DEPTH];
	bbr_pkg::cell_ctl_t         ctl;

	logic [EW-1:0] cap_eff, cfg_cap, fill_x, pos_x, end_x, clen_x, free_x;
	logic [EW-1:0] fill_n, fill_o;
	logic          in_fire, out_fire, cfg_fire;
	logic          chunk_ok, chunk_n, st, wr, rm_go, load_out, rm_last;
	logic [bbr_pkg::BYTE_W-1:0] rb;
	bbr_pkg::action_t act;

	assign cap_eff  = sat_cap(cap_q);
	assign cfg_cap  = sat_cap(cfg.data);
	assign fill_x   = EW'(fill_q);
	assign pos_x    = EW'(in_ch.position);
	assign end_x    = EW'(in_ch.end_position);
	assign clen_x   = EW'(in_ch.chunk_length);
	assign free_x   = cap_eff - fill_x;
	assign act      = bbr_pkg::action_t'(in_ch.action);
	assign chunk_ok = in_ch.first_of_chunk ? (free_x >= clen_x) : chunk_q;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_fire = out_valid_q && out_ch.ready;
	assign cfg_fire = cfg.valid && cfg.ready;
	assign rm_last  = busy_q && cnt_q == CW'(1);

	always_comb begin
		fill_n  = fill_x;
		chunk_n = chunk_q;
		st      = 1'b0;
		rb      = '0;
		wr      = 1'b0;
		rm_go   = 1'b0;
		case (act)
			bbr_pkg::ACT_APPEND: begin
				chunk_n = chunk_ok;
				if (chunk_ok && fill_x < cap_eff) begin
					wr     = 1'b1;
					fill_n = fill_x + EW'(1);
				end else begin
					st = 1'b1;
				end
			end
			bbr_pkg::ACT_READ: begin
				if (pos_x < fill_x) begin
					rb = cell_byte[pos_x[AW-1:0]];
				end else begin
					st = 1'b1;
				end
			end
			bbr_pkg::ACT_REMOVE: begin
				if (pos_x >= end_x || pos_x >= fill_x || end_x > fill_x) begin
					st = 1'b1;
				end else begin
					rm_go  = 1'b1;
					fill_n = fill_x - (end_x - pos_x);
				end
			end
			bbr_pkg::ACT_CLEAR: begin
				fill_n  = '0;
				chunk_n = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign load_out = (in_fire && !rm_go) || rm_last;
	assign fill_o   = in_fire ? fill_n : fill_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= bbr_pkg::CAP_RESET;
			fill_q      <= '0;
			chunk_q     <= 1'b0;
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			start_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_fire) begin
				cap_q <= cfg.data;
			end
			if (in_fire) begin
				fill_q  <= CW'(fill_n);
				chunk_q <= chunk_n;
				if (rm_go) begin
					busy_q  <= 1'b1;
					cnt_q   <= CW'(end_x - pos_x);
					start_q <= pos_x[AW-1:0];
				end
			end else if (cfg_fire && fill_x > cfg_cap) begin
				fill_q <= CW'(cfg_cap);
			end
			if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (rm_last) begin
					busy_q <= 1'b0;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= in_fire ? st : 1'b0;
			out_rbyte_q  <= in_fire ? rb : '0;
			out_fill_q   <= fill_o;
			out_free_q   <= cap_eff - fill_o;
			out_empty_q  <= fill_o == '0;
			out_full_q   <= fill_o == cap_eff;
		end
	end

	assign ctl.wr   = in_fire && wr;
	assign ctl.sh   = busy_q;
	assign ctl.data = in_ch.data_byte;

	for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
		logic [bbr_pkg::BYTE_W-1:0] nxt;
		if (i == BUFFER_DEPTH - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_byte[i+1];
		end
		bbr_cell #(
			.AW  (AW),
			.IDX (i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.wr_idx   (fill_q[AW-1:0]),
			.sh_start (start_q),
			.nxt      (nxt),
			.q        (cell_byte[i])
		);
	end

	assign in_ch.ready       = !busy_q && (!out_valid_q || out_ch.ready);
	assign cfg.ready         = 1'b1;
	assign out_ch.valid      = out_valid_q;
	assign out_ch.status     = out_status_q;
	assign out_ch.read_byte  = out_rbyte_q;
	assign out_ch.fill_level = out_fill_q[bbr_pkg::LEN_W-1:0];
	assign out_ch.free_space = out_free_q[bbr_pkg::LEN_W-1:0];
	assign out_ch.is_empty   = out_empty_q;
	assign out_ch.is_full    = out_full_q;

	`BBR_ASSERT(a_busy_blocks_in, clk, arst_n, !(busy_q && in_ch.ready))
	`BBR_ASSERT(a_fill_within_cap, clk, arst_n, fill_x <= cap_eff)
	`BBR_ASSERT_NEXT(a_remove_starts_shift, clk, arst_n, in_fire && rm_go, busy_q)
	`BBR_ASSERT_NEXT(a_remove_gives_result, clk, arst_n, rm_last, out_valid_q && !busy_q)

endmodule
`default_nettype wire

// ===== tb/byte_buffer_with_range_removal_tb.sv =====
// Testbench for the byte buffer with range removal: directed and random beats.
`default_nettype none
module byte_buffer_with_range_removal_tb;

	localparam int ACT_W          = bbr_pkg::ACT_W;
	localparam int BYTE_W         = bbr_pkg::BYTE_W;
	localparam int LEN_W          = bbr_pkg::LEN_W;
	localparam int POS_W          = bbr_pkg::POS_W;
	localparam int DEPTH          = 1024;
	localparam int DEPTH_AW       = $clog2(DEPTH);
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [BYTE_W-1:0] data_byte;
		logic              first_of_chunk;
		logic [LEN_W-1:0]  chunk_length;
		logic [POS_W-1:0]  position;
		logic [LEN_W-1:0]  end_position;
	} op_beat_t;

	typedef struct packed {
		logic              status;
		logic [BYTE_W-1:0] read_byte;
		logic [LEN_W-1:0]  fill_level;
		logic [LEN_W-1:0]  free_space;
		logic              is_empty;
		logic              is_full;
	} status_beat_t;

	logic clk;
	logic arst_n;

	bbr_in_if  in_ch();
	bbr_out_if out_ch();
	bbr_cfg_if cfg();

	byte_buffer_with_range_removal #(.BUFFER_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	logic [BYTE_W-1:0] model_bytes [DEPTH];
	int                model_fill;
	bit                model_chunk_ok;
	logic [LEN_W-1:0]  model_capacity;
	status_beat_t      pending_status [$];
	int                mismatches = 0;
	int                stall_cycles = 0;
	bit                no_idle = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int usable_capacity();
		int c;
		c = int'(model_capacity);
		if (c < bbr_pkg::MIN_CAP) c = bbr_pkg::MIN_CAP;
		if (c > DEPTH) c = DEPTH;
		return c;
	endfunction

	function automatic void capacity_apply(logic [LEN_W-1:0] value);
		model_capacity = value;
		if (model_fill > usable_capacity()) model_fill = usable_capacity();
	endfunction

	function automatic status_beat_t buffer_apply(op_beat_t b);
		status_beat_t r;
		int cap;
		int start;
		int stop;
		cap = usable_capacity();
		start = int'(b.position);
		stop = int'(b.end_position);
		r = '0;
		case (b.action)
			bbr_pkg::ACT_APPEND: begin
				if (b.first_of_chunk)
					model_chunk_ok = (cap - model_fill) >= int'(b.chunk_length);
				if (model_chunk_ok && model_fill < cap) begin
					model_bytes[DEPTH_AW'(model_fill)] = b.data_byte;
					model_fill++;
				end else begin
					r.status = 1'b1;
				end
			end
			bbr_pkg::ACT_READ: begin
				if (start < model_fill) r.read_byte = model_bytes[DEPTH_AW'(start)];
				else r.status = 1'b1;
			end
			bbr_pkg::ACT_REMOVE: begin
				if (start >= stop || start >= model_fill || stop > model_fill) begin
					r.status = 1'b1;
				end else begin
					for (int i = 0; i < model_fill - stop; i++)
						model_bytes[DEPTH_AW'(start + i)] = model_bytes[DEPTH_AW'(stop + i)];
					model_fill -= stop - start;
				end
			end
			bbr_pkg::ACT_CLEAR: begin
				model_fill = 0;
				model_chunk_ok = 1'b0;
			end
			default: begin
			end
		endcase
		r.fill_level = LEN_W'(model_fill);
		r.free_space = LEN_W'(cap - model_fill);
		r.is_empty = (model_fill == 0);
		r.is_full = (model_fill == cap);
		return r;
	endfunction

	function automatic op_beat_t noise_op();
		op_beat_t b;
		b.action = ACT_W'($urandom_range(0, 7));
		b.data_byte = BYTE_W'($urandom);
		b.first_of_chunk = 1'($urandom_range(0, 1));
		b.chunk_length = LEN_W'($urandom);
		b.position = POS_W'($urandom);
		b.end_position = LEN_W'($urandom);
		return b;
	endfunction

	function automatic op_beat_t make_op(logic [ACT_W-1:0] action, logic [BYTE_W-1:0] data,
		logic first, logic [LEN_W-1:0] clen, logic [POS_W-1:0] pos, logic [LEN_W-1:0] endp);
		op_beat_t b;
		b.action = action;
		b.data_byte = data;
		b.first_of_chunk = first;
		b.chunk_length = clen;
		b.position = pos;
		b.end_position = endp;
		return b;
	endfunction

	task automatic send_op(op_beat_t b);
		while (!no_idle && $urandom_range(0, 99) < 25) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.action <= b.action;
		in_ch.data_byte <= b.data_byte;
		in_ch.first_of_chunk <= b.first_of_chunk;
		in_ch.chunk_length <= b.chunk_length;
		in_ch.position <= b.position;
		in_ch.end_position <= b.end_position;
		do @(posedge clk); while (!in_ch.ready);
		pending_status.push_back(buffer_apply(b));
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_status.size() != 0);
	endtask

	task automatic set_capacity(logic [LEN_W-1:0] value);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		capacity_apply(value);
	endtask

	task automatic run_random(int count, int max_chunk, int clear_pct);
		op_beat_t b;
		int sent;
		int pick;
		int len;
		int start;
		int span;
		sent = 0;
		while (sent < count) begin
			pick = int'($urandom_range(0, 99));
			b = noise_op();
			if ($urandom_range(0, 99) == 0) wait_drained();
			if (pick < 50) begin
				len = int'($urandom_range(1, max_chunk));
				b.action = bbr_pkg::ACT_APPEND;
				case ($urandom_range(0, 9))
					7: b.chunk_length = LEN_W'(len + int'($urandom_range(0, 3)));
					8: b.chunk_length = LEN_W'((len > 1) ? len - 1 : 0);
					9: b.chunk_length = LEN_W'($urandom);
					default: b.chunk_length = LEN_W'(len);
				endcase
				for (int k = 0; k < len; k++) begin
					b.first_of_chunk = (k == 0);
					b.data_byte = BYTE_W'($urandom);
					send_op(b);
				end
				sent += len;
			end else if (pick < 65) begin
				len = int'($urandom_range(1, 4));
				b.action = bbr_pkg::ACT_READ;
				for (int k = 0; k < len; k++) begin
					if (model_fill > 0 && $urandom_range(0, 9) < 9)
						b.position = POS_W'($urandom_range(0, model_fill - 1));
					else
						b.position = POS_W'($urandom);
					send_op(b);
				end
				sent += len;
			end else if (pick < 80) begin
				b.action = bbr_pkg::ACT_REMOVE;
				if (model_fill > 0 && $urandom_range(0, 9) < 8) begin
					start = int'($urandom_range(0, model_fill - 1));
					if ($urandom_range(0, 24) == 0)
						span = model_fill - start;
					else
						span = int'($urandom_range(1,
							(model_fill - start < 8) ? model_fill - start : 8));
					b.position = POS_W'(start);
					b.end_position = LEN_W'(start + span);
				end
				send_op(b);
				sent++;
			end else if (pick < 80 + clear_pct) begin
				b.action = bbr_pkg::ACT_CLEAR;
				send_op(b);
				sent++;
			end else if (pick < 90) begin
				b.action = ($urandom_range(0, 1) != 0) ? bbr_pkg::ACT_QUERY
					: ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
				send_op(b);
				sent++;
			end else begin
				send_op(b);
				sent++;
			end
		end
	endtask

	task automatic test_directed_cases();
		send_op(make_op(bbr_pkg::ACT_APPEND, 8'h00, 1'b1, 11'd3, '0, '0));
		send_op(make_op(bbr_pkg::ACT_APPEND, 8'hFF, 1'b0, '0, '0, '0));
		send_op(make_op(bbr_pkg::ACT_APPEND, 8'hA5, 1'b0, '0, '0, '0));
		send_op(make_op(bbr_pkg::ACT_READ, '0, 1'b0, '0, 10'd0, '0));
		send_op(make_op(bbr_pkg::ACT_READ, '0, 1'b0, '0, 10'd2, '0));
		send_op(make_op(bbr_pkg::ACT_READ, '0, 1'b0, '0, 10'd3, '0));
		send_op(make_op(bbr_pkg::ACT_READ, '0, 1'b1, 11'h7FF, 10'h3FF, 11'h7FF));
		send_op(make_op(bbr_pkg::ACT_QUERY, '0, 1'b0, '0, '0, '0));
		send_op(make_op(ACT_SPARE_LAST, 8'hFF, 1'b1, 11'h7FF, 10'h3FF, 11'h7FF));
		send_op(make_op(ACT_SPARE_FIRST, '0, 1'b0, '0, '0, '0));
		send_op(make_op(bbr_pkg::ACT_REMOVE, '0, 1'b0, '0, 10'd2, 11'd2));
		send_op(make_op(bbr_pkg::ACT_REMOVE, '0, 1'b0, '0, 10'd3, 11'd4));
		send_op(make_op(bbr_pkg::ACT_REMOVE, '0, 1'b0, '0, 10'd1, 11'h7FF));
		send_op(make_op(bbr_pkg::ACT_REMOVE, '0, 1'b0, '0, 10'd0, 11'd1));
		send_op(make_op(bbr_pkg::ACT_READ, '0, 1'b0, '0, 10'd0, '0));
		send_op(make_op(bbr_pkg::ACT_APPEND, 8'h5A, 1'b1, 11'd0, '0, '0));
		send_op(make_op(bbr_pkg::ACT_CLEAR, '0, 1'b0, '0, '0, '0));
		send_op(make_op(bbr_pkg::ACT_READ, '0, 1'b0, '0, 10'd0, '0));
		send_op(make_op(bbr_pkg::ACT_APPEND, 8'h3C, 1'b0, '0, '0, '0));
		send_op(make_op(bbr_pkg::ACT_APPEND, 8'hC3, 1'b1, 11'h7FF, '0, '0));
		send_op(make_op(bbr_pkg::ACT_APPEND, 8'h81, 1'b0, '0, '0, '0));
		send_op(make_op(bbr_pkg::ACT_QUERY, '0, 1'b0, '0, '0, '0));
	endtask

	task automatic test_large_fill();
		op_beat_t b;
		int len;
		set_capacity(11'h7FF);
		run_random(300, 200, 0);
		len = usable_capacity() - model_fill;
		b = noise_op();
		b.action = bbr_pkg::ACT_APPEND;
		b.chunk_length = LEN_W'(len);
		for (int k = 0; k < len + 2; k++) begin
			b.first_of_chunk = (k == 0);
			b.data_byte = BYTE_W'($urandom);
			send_op(b);
		end
		b.action = bbr_pkg::ACT_REMOVE;
		b.position = POS_W'(1);
		b.end_position = LEN_W'(model_fill - 3);
		send_op(b);
		b.action = bbr_pkg::ACT_READ;
		b.position = POS_W'(1);
		send_op(b);
	endtask

	task automatic test_capacity_cut();
		set_capacity(11'd0);
		run_random(250, 12, 5);
		set_capacity(11'd20);
		run_random(250, 12, 5);
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		set_capacity(11'd1024);
		run_random(350, 64, 3);
		wait_drained();
		no_idle = 1'b0;
	endtask

	task automatic test_mid_capacity();
		set_capacity(LEN_W'($urandom_range(21, 1023)));
		run_random(300, 40, 5);
	endtask

	always @(posedge clk) begin
		out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 25);
	end

	task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_results
		status_beat_t want;
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_status.size() == 0) begin
				$error("result beat with no pending item");
				mismatches++;
			end else begin
				want = pending_status.pop_front();
				check_field("status", 16'(want.status), 16'(out_ch.status));
				check_field("read_byte", 16'(want.read_byte), 16'(out_ch.read_byte));
				check_field("fill_level", 16'(want.fill_level), 16'(out_ch.fill_level));
				check_field("free_space", 16'(want.free_space), 16'(out_ch.free_space));
				check_field("is_empty", 16'(want.is_empty), 16'(out_ch.is_empty));
				check_field("is_full", 16'(want.is_full), 16'(out_ch.is_full));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
			|| (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			|| (cfg.valid === 1'b1 && cfg.ready === 1'b1)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("byte_buffer_with_range_removal_tb failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.action <= bbr_pkg::ACT_QUERY;
		in_ch.data_byte <= '0;
		in_ch.first_of_chunk <= 1'b0;
		in_ch.chunk_length <= '0;
		in_ch.position <= '0;
		in_ch.end_position <= '0;
		cfg.valid <= 1'b0;
		cfg.data <= bbr_pkg::CAP_RESET;
		model_fill = 0;
		model_chunk_ok = 1'b0;
		model_capacity = bbr_pkg::CAP_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_large_fill();
		test_capacity_cut();
		test_back_to_back();
		test_mid_capacity();
		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("byte_buffer_with_range_removal_tb passed");
		end else begin
			$display("byte_buffer_with_range_removal_tb failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/bbr_pkg.sv
rtl/bbr_if.sv
rtl/bbr_cell.sv
rtl/byte_buffer_with_range_removal.sv
tb/byte_buffer_with_range_removal_tb.sv
